### src/thick_line_framebuffer_drawer_core_macros.svh
// Assertion macros for the thick line drawer checker.
// Included by the checker file only.
`ifndef THICK_LINE_FRAMEBUFFER_DRAWER_CORE_MACROS_SVH
`define THICK_LINE_FRAMEBUFFER_DRAWER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TLD_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tld check failed");
// Next-cycle implication checked outside reset.
`define TLD_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tld check failed");
`endif

### src/tld_pkg.sv
// Package for the thick line drawer: request codes and defaults.
// No dependencies.
package tld_pkg;
  localparam int ScreenWidthDef  = 128;
  localparam int ScreenHeightDef = 64;
  localparam int MaxThickDef     = 50;
  localparam int QueueDepth      = 2;

  typedef enum logic {
    REQ_DRAW = 1'b0,
    REQ_READ = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] sx;
    logic [6:0] sy;
    logic [7:0] ex;
    logic [6:0] ey;
    logic [6:0] width;
    logic       color;
    logic [9:0] index;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_SETUP,
    BK_PIX,
    BK_RMW,
    BK_READ,
    BK_REPLY
  } back_state_t;
endpackage

### src/tld_front.sv
// Front end of the thick line drawer: accepts items, saturates the width,
// and queues decoded commands. Depends on tld_pkg.
module tld_front import tld_pkg::*; #(
  parameter int MAX_THICKNESS = MaxThickDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [45:0] in_data,
  output logic       q_valid,
  input  logic       q_pop,
  output cmd_t       q_cmd
);
  cmd_t       slots [QueueDepth];
  logic [1:0] count;
  logic       wr_ptr, rd_ptr;
  cmd_t       dec;
  logic [7:0] thick;

  always_comb begin
    thick = in_data[34:27];
    dec.kind  = in_data[0];
    dec.sx    = {1'b0, in_data[7:1]};
    dec.sy    = {1'b0, in_data[13:8]};
    dec.ex    = {1'b0, in_data[20:14]};
    dec.ey    = {1'b0, in_data[26:21]};
    dec.width = (thick > 8'(MAX_THICKNESS)) ? 7'(MAX_THICKNESS) : thick[6:0];
    dec.color = in_data[35];
    dec.index = in_data[45:36];
  end

  assign in_ready = (count != 2'(QueueDepth));
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slots[wr_ptr] <= dec;
    if (rst) begin
      count <= '0; wr_ptr <= 1'b0; rd_ptr <= 1'b0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(q_pop);
    end
  end
endmodule

### src/tld_back.sv
// Back end of the thick line drawer: clears the frame store, rasterizes
// lines one pixel per read-modify-write, and answers reads. Depends on tld_pkg.
module tld_back import tld_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [8:0] res_data
);
  localparam int Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int Bytes = SCREEN_WIDTH * Pages;
  localparam int AW    = $clog2(Bytes);

  logic [7:0]  mem [Bytes];
  logic [7:0]  rdata;
  logic [AW-1:0] raddr, waddr;
  logic        we;
  logic [7:0]  wdata;
  back_state_t state, state_next;
  cmd_t        cmd;
  logic [AW:0] clr;
  // Walker registers, signed 10 bits.
  logic signed [9:0] x0, y0, x1, y1, ddx, ddy, di, cur, hi;
  logic        sxn, syn, xmaj, band;
  logic [2:0]  mode; // 0 vband 1 hband 2 bres
  logic signed [9:0] cc, lo, bandhi, px, py, tv;
  logic [2:0]  pbit;
  logic        done_seg, last_pt;
  logic [8:0]  res_reg;
  logic        res_full;

  // Pixel currently addressed.
  always_comb begin
    case (mode)
      3'd0: begin px = cc;  py = cur; end
      3'd1: begin px = cur; py = cc;  end
      default: begin
        if (xmaj) begin px = x0; py = cur; end
        else begin px = cur; py = y0; end
      end
    endcase
    pbit  = 3'(7 - (py % 8));
    raddr = AW'(px + (Pages - 1 - py / 8) * SCREEN_WIDTH);
    done_seg = (cur >= hi);
    last_pt  = xmaj ? (x0 == x1) : (y0 == y1);
    tv = 10'sd0;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      BK_IDLE: if (q_valid && !res_full) begin
        q_pop = 1'b1;
        state_next = (q_cmd.kind == REQ_READ) ? BK_READ : BK_SETUP;
      end
      BK_CLEAR: if (clr == (AW+1)'(Bytes - 1)) state_next = BK_IDLE;
      BK_SETUP: state_next = (cmd.width == 7'd0) ? BK_REPLY : BK_PIX;
      BK_PIX:   state_next = BK_RMW;
      BK_RMW: begin
        if (done_seg && (band ? (cc >= bandhi) : last_pt)) state_next = BK_REPLY;
        else state_next = BK_PIX;
      end
      BK_READ:  state_next = BK_REPLY;
      BK_REPLY: state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  assign we    = (state == BK_CLEAR) ||
                 (state == BK_RMW && px >= 0 && py >= 0 &&
                  px < SCREEN_WIDTH && py < SCREEN_HEIGHT);
  assign waddr = (state == BK_CLEAR) ? clr[AW-1:0] : raddr;
  assign wdata = (state == BK_CLEAR) ? 8'd0 :
                 (cmd.color ? (rdata | (8'd1 << pbit)) : (rdata & ~(8'd1 << pbit)));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[(state == BK_IDLE) ? AW'(q_cmd.index) :
                 (state == BK_READ) ? AW'(cmd.index) : raddr];
  end

  always_ff @(posedge clk) begin
    logic signed [9:0] bef, aft, ndi, nx, ny, l;
    bef = 10'(cmd.width / 2);
    aft = 10'(cmd.width) - bef - 10'sd1;
    if (rst) begin
      state <= BK_CLEAR; clr <= '0; res_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr <= clr + 1'b1;
      if (res_full && res_ready) res_full <= 1'b0;
      if (state == BK_REPLY) begin
        res_full <= 1'b1;
        res_reg  <= (cmd.kind == REQ_READ) ?
                    {1'b1, (12'(cmd.index) < 12'(Bytes)) ? rdata : 8'd0} : 9'd0;
      end
    end
    if (state == BK_IDLE) cmd <= q_cmd;
    if (state == BK_SETUP) begin
      x0 <= 10'(cmd.sx); y0 <= 10'(cmd.sy); x1 <= 10'(cmd.ex); y1 <= 10'(cmd.ey);
      ddx <= (cmd.ex >= cmd.sx) ? 10'(cmd.ex - cmd.sx) : 10'(cmd.sx - cmd.ex);
      ddy <= (cmd.ey >= cmd.sy) ? 10'(cmd.ey - cmd.sy) : 10'(cmd.sy - cmd.ey);
      sxn <= cmd.ex < cmd.sx; syn <= cmd.ey < cmd.sy;
      if (cmd.ex == cmd.sx) begin
        mode <= 3'd0; band <= 1'b1;
        l = 10'(cmd.sx) - bef; cc <= (l < 0) ? 10'sd0 : l;
        bandhi <= 10'(cmd.sx) + aft;
        lo  <= (cmd.sy < cmd.ey) ? 10'(cmd.sy) : 10'(cmd.ey);
        cur <= (cmd.sy < cmd.ey) ? 10'(cmd.sy) : 10'(cmd.ey);
        hi  <= (cmd.sy < cmd.ey) ? 10'(cmd.ey) : 10'(cmd.sy);
      end else if (cmd.ey == cmd.sy) begin
        mode <= 3'd1; band <= 1'b1;
        l = 10'(cmd.sy) - bef; cc <= (l < 0) ? 10'sd0 : l;
        bandhi <= 10'(cmd.sy) + aft;
        lo  <= (cmd.sx < cmd.ex) ? 10'(cmd.sx) : 10'(cmd.ex);
        cur <= (cmd.sx < cmd.ex) ? 10'(cmd.sx) : 10'(cmd.ex);
        hi  <= (cmd.sx < cmd.ex) ? 10'(cmd.ex) : 10'(cmd.sx);
      end else begin
        mode <= 3'd2; band <= 1'b0;
        xmaj <= ((cmd.ex >= cmd.sx) ? cmd.ex - cmd.sx : cmd.sx - cmd.ex) >=
                ((cmd.ey >= cmd.sy) ? cmd.ey - cmd.sy : cmd.sy - cmd.ey);
        if (((cmd.ex >= cmd.sx) ? cmd.ex - cmd.sx : cmd.sx - cmd.ex) >=
            ((cmd.ey >= cmd.sy) ? cmd.ey - cmd.sy : cmd.sy - cmd.ey)) begin
          l = 10'(cmd.sy) - bef; cur <= (l < 0) ? 10'sd0 : l;
          hi <= 10'(cmd.sy) + aft;
          di <= 10'sd2 * ((cmd.ey >= cmd.sy) ? 10'(cmd.ey - cmd.sy) : 10'(cmd.sy - cmd.ey))
                - ((cmd.ex >= cmd.sx) ? 10'(cmd.ex - cmd.sx) : 10'(cmd.sx - cmd.ex));
        end else begin
          l = 10'(cmd.sx) - bef; cur <= (l < 0) ? 10'sd0 : l;
          hi <= 10'(cmd.sx) + aft;
          di <= 10'sd2 * ((cmd.ex >= cmd.sx) ? 10'(cmd.ex - cmd.sx) : 10'(cmd.sx - cmd.ex))
                - ((cmd.ey >= cmd.sy) ? 10'(cmd.ey - cmd.sy) : 10'(cmd.sy - cmd.ey));
        end
      end
    end
    if (state == BK_RMW) begin
      if (!done_seg) cur <= cur + 10'sd1;
      else if (band) begin
        cc <= cc + 10'sd1; cur <= lo;
      end else begin
        // Bresenham step along the major axis.
        nx = x0; ny = y0; ndi = di;
        if (xmaj) begin
          nx = sxn ? x0 - 10'sd1 : x0 + 10'sd1;
          if (di < 0) ndi = di + 10'sd2 * ddy;
          else begin ndi = di + 10'sd2 * ddy - 10'sd2 * ddx;
            ny = syn ? y0 - 10'sd1 : y0 + 10'sd1; end
          l = ny - bef; cur <= (l < 0) ? 10'sd0 : l; hi <= ny + aft;
        end else begin
          ny = syn ? y0 - 10'sd1 : y0 + 10'sd1;
          if (di < 0) ndi = di + 10'sd2 * ddx;
          else begin ndi = di + 10'sd2 * ddx - 10'sd2 * ddy;
            nx = sxn ? x0 - 10'sd1 : x0 + 10'sd1; end
          l = nx - bef; cur <= (l < 0) ? 10'sd0 : l; hi <= nx + aft;
        end
        x0 <= nx; y0 <= ny; di <= ndi + tv;
      end
    end
  end

  assign res_valid = res_full;
  assign res_data  = res_reg;
endmodule

### src/thick_line_framebuffer_drawer_core.sv
// Top level of the thick line drawer: front queue plus raster back end.
// Depends on tld_pkg, tld_front and tld_back.
//
// Channel  Dir  Contents
// s_axis   in   request item: req_type, coordinates, width, color, index
// m_axis   out  reply item: read_data, is_read_reply
//
// A read passes through the read and reply states. A draw visits each pixel
// with a memory read then a write through one port, plus setup and reply.
// After reset the back end clears the 1024-byte store; items queue in the
// two-entry front queue meanwhile. Reset is synchronous. A stalled reply
// holds the back end but the front keeps queueing.
module thick_line_framebuffer_drawer_core import tld_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef,
  parameter int MAX_THICKNESS = MaxThickDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type, start_x, start_y, end_x, end_y, thickness, pen_color,
  // read_index, zero fill.
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data, is_read_reply, zero fill.
  output logic [15:0] m_axis_tdata
);
  logic       q_valid, q_pop;
  cmd_t       q_cmd;
  logic [8:0] res;

  tld_front #(.MAX_THICKNESS(MAX_THICKNESS)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata[45:0]), .q_valid, .q_pop, .q_cmd
  );

  tld_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
  );

  assign m_axis_tdata = {7'd0, res};
endmodule

### src/tld_checker.sv
// Port-level checker for the thick line drawer, bound to the top level.
// Depends on the macros header.
`include "thick_line_framebuffer_drawer_core_macros.svh"
module tld_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  `TLD_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:9] == 7'd0)
  `TLD_ASSERT_IMP(a_draw_zero, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[7:0] == 8'd0)
  `TLD_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind thick_line_framebuffer_drawer_core tld_checker u_chk (.*);
